// ===== design/wfpd_pkg.sv =====
// wfpd_pkg.sv: shared widths, configuration struct, microcode word and program rom
// for the wall-following pd steering block; no dependencies
package wfpd_pkg;

  localparam int FRAC_BITS_DEF = 8;

  localparam int DIST_W     = 9;
  localparam int ERR_W      = 10;
  localparam int DERIV_W    = 11;
  localparam int GAIN_W     = 10;
  localparam int SPEED_W    = 8;
  localparam int CTRL_W     = 11;
  localparam int SUM_W      = 24;
  localparam int ACC_W      = 27;
  localparam int MODE_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int PC_W       = 4;
  localparam int N_W        = 14;
  localparam int N_SHIFT    = 4;
  localparam int Q_W        = 11;
  localparam int RECIP_W    = 13;
  localparam int RECIP_SHIFT = 16;

  // 16*|c| is saturated here, far past every output limit
  localparam logic [N_W-1:0] N_MAX = 14'd16383;
  // ceil(2^16 / 10)
  localparam logic [RECIP_W-1:0] RECIP_M = 13'd6554;

  localparam logic signed [ACC_W-1:0] SUM_HI = 27'sd8388607;
  localparam logic signed [ACC_W-1:0] SUM_LO = -27'sd8388608;
  localparam logic signed [CTRL_W-1:0] CTRL_HI = 11'sd1023;
  localparam logic signed [CTRL_W-1:0] CTRL_LO = -11'sd1023;
  localparam int SPEED_MAX = 255;

  localparam logic [MODE_W-1:0] MODE_SCALED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TARGET     = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_GAIN_I     = 3'd3,
    REG_BASE_LEFT  = 3'd4,
    REG_BASE_RIGHT = 3'd5,
    REG_NO_ECHO    = 3'd6,
    REG_MODE       = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [DIST_W-1:0]  target_distance;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_d;
    logic [GAIN_W-1:0]  gain_i;
    logic [SPEED_W-1:0] base_speed_left;
    logic [SPEED_W-1:0] base_speed_right;
    logic [DIST_W-1:0]  no_echo_distance;
    logic [MODE_W-1:0]  steer_mode;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DECAY_SUM,
    MUL_GI_ERR,
    MUL_GP_ERR,
    MUL_GD_DERIV,
    MUL_RECIP
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_ERR,
    ACC_ROUND,
    ACC_ADD_SAT,
    ACC_ADD,
    ACC_CEIL
  } acc_op_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_SCALED,
    OUT_PLAIN
  } out_op_t;

  typedef enum logic {
    JMP_NEXT,
    JMP_IF_NOT_SCALED
  } jmp_t;

  typedef struct packed {
    mul_sel_t        mul_sel;
    acc_op_t         acc_op;
    out_op_t         out_op;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
    logic            last;
  } ucode_t;

  typedef struct packed {
    logic     load_in;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    out_op_t  out_op;
    logic     out_we;
  } dp_ctrl_t;

  localparam logic [PC_W-1:0] STEP_PLAIN = 4'd9;

  // program: error, decay product, round, saturate sum, p term, d term,
  // then either the ceil/scale branch or the plain output step
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, out_op: OUT_NONE,
          jmp: JMP_NEXT, target: '0, last: 1'b0};
    case (pc)
      4'd0: w.acc_op = ACC_ERR;
      4'd1: w.mul_sel = MUL_DECAY_SUM;
      4'd2: begin
        w.acc_op  = ACC_ROUND;
        w.mul_sel = MUL_GI_ERR;
      end
      4'd3: begin
        w.acc_op  = ACC_ADD_SAT;
        w.mul_sel = MUL_GP_ERR;
      end
      4'd4: begin
        w.acc_op  = ACC_ADD;
        w.mul_sel = MUL_GD_DERIV;
      end
      4'd5: begin
        w.acc_op = ACC_ADD;
        w.jmp    = JMP_IF_NOT_SCALED;
        w.target = STEP_PLAIN;
      end
      4'd6: w.acc_op = ACC_CEIL;
      4'd7: w.mul_sel = MUL_RECIP;
      4'd8: begin
        w.out_op = OUT_SCALED;
        w.last   = 1'b1;
      end
      4'd9: begin
        w.out_op = OUT_PLAIN;
        w.last   = 1'b1;
      end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

endpackage

// ===== design/wfpd_seq.sv =====
// wfpd_seq.sv: step counter, program rom lookup and stream handshakes
// depends on wfpd_pkg
module wfpd_seq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  logic [wfpd_pkg::MODE_W-1:0]     mode,
  output wfpd_pkg::dp_ctrl_t              ctrl
);

  logic                        busy;
  logic [wfpd_pkg::PC_W-1:0]   pc;
  logic [wfpd_pkg::PC_W-1:0]   pc_next;
  wfpd_pkg::ucode_t            uw;
  logic                        out_free;

  assign uw       = wfpd_pkg::ucode_rom(pc);
  assign out_free = !out_valid || out_ready;
  assign in_ready = !busy;

  always_comb begin
    if (uw.jmp == wfpd_pkg::JMP_IF_NOT_SCALED && mode != wfpd_pkg::MODE_SCALED) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_comb begin
    ctrl.load_in = !busy && in_valid;
    ctrl.mul_sel = busy ? uw.mul_sel : wfpd_pkg::MUL_NONE;
    ctrl.acc_op  = busy ? uw.acc_op : wfpd_pkg::ACC_HOLD;
    ctrl.out_op  = uw.out_op;
    ctrl.out_we  = busy && uw.last && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.out_we) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (!busy) begin
        if (in_valid) begin
          busy <= 1'b1;
          pc   <= '0;
        end
      end else if (uw.last) begin
        // hold on the last step until the output register frees up
        if (out_free) begin
          busy <= 1'b0;
        end
      end else begin
        pc <= pc_next;
      end
    end
  end

endmodule

// ===== design/wfpd_dp.sv =====
// wfpd_dp.sv: shared multiplier, accumulator, loop state and output registers
// driven one control word per cycle; depends on wfpd_pkg
module wfpd_dp #(
  parameter int FRAC_BITS = wfpd_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wfpd_pkg::cfg_t                      cfg,
  input  wfpd_pkg::dp_ctrl_t                  ctrl,
  input  logic [wfpd_pkg::DIST_W-1:0]         distance_cm,
  output logic [wfpd_pkg::SPEED_W-1:0]        speed_left,
  output logic [wfpd_pkg::SPEED_W-1:0]        speed_right,
  output logic signed [wfpd_pkg::CTRL_W-1:0]  control_value
);

  localparam int ACC_W = wfpd_pkg::ACC_W;
  localparam int SUM_W = wfpd_pkg::SUM_W;
  localparam int N_W   = wfpd_pkg::N_W;
  localparam int Q_W   = wfpd_pkg::Q_W;
  localparam int A_W   = SUM_W + 1;
  localparam int B_W   = ((FRAC_BITS > wfpd_pkg::RECIP_W) ? FRAC_BITS : wfpd_pkg::RECIP_W) + 1;
  localparam int P_W   = A_W + B_W;
  localparam int DECAY_Q = ((7 << FRAC_BITS) + 5) / 10;

  localparam logic signed [P_W-1:0]   HALF_P   = P_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] CEIL_ADD = ACC_W'((1 << FRAC_BITS) - 1);
  localparam logic [ACC_W-1:0]        MAG_LIM  = ACC_W'(wfpd_pkg::N_MAX >> wfpd_pkg::N_SHIFT);

  // loop state
  logic signed [SUM_W-1:0]              leaky_sum;
  logic signed [wfpd_pkg::ERR_W-1:0]    previous_error;

  // working registers
  logic [wfpd_pkg::DIST_W-1:0]          dist_in;
  logic signed [wfpd_pkg::ERR_W-1:0]    err;
  logic signed [wfpd_pkg::DERIV_W-1:0]  deriv;
  logic signed [ACC_W-1:0]              acc;
  logic signed [P_W-1:0]                p;
  logic [N_W-1:0]                       n;

  // combinational
  logic [wfpd_pkg::DIST_W-1:0]          dist_eff;
  logic signed [wfpd_pkg::ERR_W-1:0]    err_n;
  logic signed [wfpd_pkg::DERIV_W-1:0]  deriv_n;
  logic signed [A_W-1:0]                mul_a;
  logic signed [B_W-1:0]                mul_b;
  logic signed [P_W-1:0]                prod;
  logic signed [P_W-1:0]                p_round;
  logic signed [ACC_W-1:0]              add_res;
  logic signed [ACC_W-1:0]              sum_sat;
  logic signed [ACC_W-1:0]              ceil_v;
  logic [ACC_W-1:0]                     mag;
  logic [N_W-1:0]                       n_next;

  logic [Q_W-1:0]                       qe;
  logic [N_W:0]                         ten_q;
  logic [N_W:0]                         tq;
  logic                                 over;
  logic                                 up;
  logic [Q_W-1:0]                       q;
  logic [wfpd_pkg::SPEED_W+3:0]         left_s;
  logic [wfpd_pkg::SPEED_W+3:0]         qc;
  logic [wfpd_pkg::SPEED_W+3:0]         br_x;
  logic [wfpd_pkg::SPEED_W-1:0]         sc_left;
  logic [wfpd_pkg::SPEED_W-1:0]         sc_right;
  logic signed [ACC_W-1:0]              q_s;
  logic signed [ACC_W-1:0]              sc_ctrl_full;

  logic                                 mirror;
  logic signed [ACC_W:0]                acc_x;
  logic signed [ACC_W:0]                bl_q;
  logic signed [ACC_W:0]                br_q;
  logic signed [ACC_W:0]                ls;
  logic signed [ACC_W:0]                rs;
  logic signed [ACC_W-1:0]              trunc_bias;
  logic signed [ACC_W-1:0]              pl_ctrl_full;

  function automatic logic [wfpd_pkg::SPEED_W-1:0] speed_sat(input logic signed [ACC_W:0] x);
    logic signed [ACC_W:0] w;
    w = x >>> FRAC_BITS;
    if (x < 0) begin
      return '0;
    end else if (w > wfpd_pkg::SPEED_MAX) begin
      return wfpd_pkg::SPEED_W'(wfpd_pkg::SPEED_MAX);
    end
    return w[wfpd_pkg::SPEED_W-1:0];
  endfunction

  function automatic logic signed [wfpd_pkg::CTRL_W-1:0] ctrl_clamp(
    input logic signed [ACC_W-1:0] v
  );
    if (v > wfpd_pkg::CTRL_HI) begin
      return wfpd_pkg::CTRL_HI;
    end else if (v < wfpd_pkg::CTRL_LO) begin
      return wfpd_pkg::CTRL_LO;
    end
    return v[wfpd_pkg::CTRL_W-1:0];
  endfunction

  // error and derivative
  assign dist_eff = (dist_in == '0) ? cfg.no_echo_distance : dist_in;
  assign err_n    = signed'({1'b0, cfg.target_distance}) - signed'({1'b0, dist_eff});
  assign deriv_n  = {err_n[wfpd_pkg::ERR_W-1], err_n}
                  - {previous_error[wfpd_pkg::ERR_W-1], previous_error};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_sel)
      wfpd_pkg::MUL_DECAY_SUM: begin
        mul_a = {{(A_W-SUM_W){leaky_sum[SUM_W-1]}}, leaky_sum};
        mul_b = B_W'(DECAY_Q);
      end
      wfpd_pkg::MUL_GI_ERR: begin
        mul_a = {{(A_W-wfpd_pkg::ERR_W){err[wfpd_pkg::ERR_W-1]}}, err};
        mul_b = {{(B_W-wfpd_pkg::GAIN_W){1'b0}}, cfg.gain_i};
      end
      wfpd_pkg::MUL_GP_ERR: begin
        mul_a = {{(A_W-wfpd_pkg::ERR_W){err[wfpd_pkg::ERR_W-1]}}, err};
        mul_b = {{(B_W-wfpd_pkg::GAIN_W){1'b0}}, cfg.gain_p};
      end
      wfpd_pkg::MUL_GD_DERIV: begin
        mul_a = {{(A_W-wfpd_pkg::DERIV_W){deriv[wfpd_pkg::DERIV_W-1]}}, deriv};
        mul_b = {{(B_W-wfpd_pkg::GAIN_W){1'b0}}, cfg.gain_d};
      end
      wfpd_pkg::MUL_RECIP: begin
        mul_a = {{(A_W-N_W){1'b0}}, n};
        mul_b = {{(B_W-wfpd_pkg::RECIP_W){1'b0}}, wfpd_pkg::RECIP_M};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // accumulator arithmetic
  assign p_round = (p + HALF_P) >>> FRAC_BITS;
  assign add_res = acc + signed'(p[ACC_W-1:0]);
  assign sum_sat = (add_res > wfpd_pkg::SUM_HI) ? wfpd_pkg::SUM_HI :
                   (add_res < wfpd_pkg::SUM_LO) ? wfpd_pkg::SUM_LO : add_res;
  assign ceil_v  = (acc + CEIL_ADD) >>> FRAC_BITS;
  assign mag     = ceil_v[ACC_W-1] ? unsigned'(-ceil_v) : unsigned'(ceil_v);
  assign n_next  = (mag > MAG_LIM) ? wfpd_pkg::N_MAX :
                   {mag[N_W-wfpd_pkg::N_SHIFT-1:0], {wfpd_pkg::N_SHIFT{1'b0}}};

  // scaled branch: divide by ten via reciprocal, one correction
  assign qe       = p[wfpd_pkg::RECIP_SHIFT +: Q_W];
  assign ten_q    = {1'b0, qe, 3'b000} + {3'b000, qe, 1'b0};
  assign over     = ten_q > {1'b0, n};
  assign q        = over ? qe - 1'b1 : qe;
  assign tq       = over ? ten_q - (N_W+1)'(10) : ten_q;
  assign up       = tq != {1'b0, n};
  assign left_s   = {4'b0000, cfg.base_speed_left} + {1'b0, q};
  assign qc       = {1'b0, q} + {{(wfpd_pkg::SPEED_W+3){1'b0}}, up};
  assign br_x     = {4'b0000, cfg.base_speed_right};
  assign sc_left  = (left_s > (wfpd_pkg::SPEED_W+4)'(wfpd_pkg::SPEED_MAX)) ?
                    wfpd_pkg::SPEED_W'(wfpd_pkg::SPEED_MAX) : left_s[wfpd_pkg::SPEED_W-1:0];
  assign sc_right = (br_x < qc) ? '0 : wfpd_pkg::SPEED_W'(br_x - qc);
  assign q_s      = signed'({{(ACC_W-Q_W){1'b0}}, q});
  assign sc_ctrl_full = acc[ACC_W-1] ? -q_s : q_s;

  // plain branch: speeds in Q format, control truncated toward zero
  assign mirror       = cfg.steer_mode == wfpd_pkg::MODE_MIRROR;
  assign acc_x        = {acc[ACC_W-1], acc};
  assign bl_q         = signed'((ACC_W+1)'(cfg.base_speed_left)) <<< FRAC_BITS;
  assign br_q         = signed'((ACC_W+1)'(cfg.base_speed_right)) <<< FRAC_BITS;
  assign ls           = mirror ? bl_q - acc_x : bl_q + acc_x;
  assign rs           = mirror ? br_q + acc_x : br_q - acc_x;
  assign trunc_bias   = CEIL_ADD & {ACC_W{acc[ACC_W-1]}};
  assign pl_ctrl_full = (acc + trunc_bias) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      leaky_sum      <= '0;
      previous_error <= '0;
    end else begin
      if (ctrl.acc_op == wfpd_pkg::ACC_ERR) begin
        previous_error <= err_n;
      end
      if (ctrl.acc_op == wfpd_pkg::ACC_ADD_SAT) begin
        leaky_sum <= sum_sat[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      dist_in <= distance_cm;
    end
    if (ctrl.mul_sel != wfpd_pkg::MUL_NONE) begin
      p <= prod;
    end
    case (ctrl.acc_op)
      wfpd_pkg::ACC_ERR: begin
        err   <= err_n;
        deriv <= deriv_n;
      end
      wfpd_pkg::ACC_ROUND:   acc <= p_round[ACC_W-1:0];
      wfpd_pkg::ACC_ADD_SAT: acc <= sum_sat;
      wfpd_pkg::ACC_ADD:     acc <= add_res;
      wfpd_pkg::ACC_CEIL: begin
        acc <= ceil_v;
        n   <= n_next;
      end
      default: ;
    endcase
    if (ctrl.out_we) begin
      case (ctrl.out_op)
        wfpd_pkg::OUT_SCALED: begin
          speed_left    <= sc_left;
          speed_right   <= sc_right;
          control_value <= ctrl_clamp(sc_ctrl_full);
        end
        wfpd_pkg::OUT_PLAIN: begin
          speed_left    <= speed_sat(ls);
          speed_right   <= speed_sat(rs);
          control_value <= ctrl_clamp(pl_ctrl_full);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/wall_follow_pd_steering.sv =====
// wall_follow_pd_steering.sv: top level of the pd wall-following steering block
// holds the configuration registers, ties the sequencer to the datapath
// depends on wfpd_pkg, wfpd_seq, wfpd_dp
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+----------------------------------
//  s_axis    | in        | s_axis_tvalid, s_axis_tready | tdata[8:0] distance_cm
//  m_axis    | out       | m_axis_tvalid, m_axis_tready | tdata[7:0] speed_left,
//            |           |                              | [15:8] speed_right, [26:16] control
//  cfg       | in        | cfg_we (no wait)             | cfg_addr register, cfg_data value
//
// an item runs through a microcode program of one step per cycle, but for a stall on
// its last step; steer mode 1 adds ceil and divide-by-ten steps that modes 0, 2 and 3 skip;
// the shared multiplier is used at most once per step and sets the program length
// a new item is taken once the previous one has left the program, while its
// result may still sit in the output register
// a finished item waits on its last step while the output register is full
// synchronous reset restores the register defaults and clears the leaky sum
// and the previous error; no clearing pass is needed
module wall_follow_pd_steering #(
  parameter int FRAC_BITS = wfpd_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,   // [8:0] distance_cm
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [31:0]                         m_axis_tdata,   // [7:0] speed_left,
                                                              // [15:8] speed_right,
                                                              // [26:16] control_value
  input  logic                                cfg_we,
  input  logic [wfpd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [wfpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  wfpd_pkg::cfg_t                          cfg;
  wfpd_pkg::dp_ctrl_t                      ctrl;
  logic [wfpd_pkg::SPEED_W-1:0]            speed_left;
  logic [wfpd_pkg::SPEED_W-1:0]            speed_right;
  logic signed [wfpd_pkg::CTRL_W-1:0]      control_value;

  // configuration registers, to be written by the user only while the block is idle; nothing in the block enforces this
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_distance  <= 9'd4;
      cfg.gain_p           <= 10'd97;
      cfg.gain_d           <= 10'd61;
      cfg.gain_i           <= 10'd0;
      cfg.base_speed_left  <= 8'd60;
      cfg.base_speed_right <= 8'd55;
      cfg.no_echo_distance <= 9'd200;
      cfg.steer_mode       <= 2'd0;
    end else if (cfg_we) begin
      case (wfpd_pkg::cfg_reg_t'(cfg_addr))
        wfpd_pkg::REG_TARGET:     cfg.target_distance  <= cfg_data[wfpd_pkg::DIST_W-1:0];
        wfpd_pkg::REG_GAIN_P:     cfg.gain_p           <= cfg_data[wfpd_pkg::GAIN_W-1:0];
        wfpd_pkg::REG_GAIN_D:     cfg.gain_d           <= cfg_data[wfpd_pkg::GAIN_W-1:0];
        wfpd_pkg::REG_GAIN_I:     cfg.gain_i           <= cfg_data[wfpd_pkg::GAIN_W-1:0];
        wfpd_pkg::REG_BASE_LEFT:  cfg.base_speed_left  <= cfg_data[wfpd_pkg::SPEED_W-1:0];
        wfpd_pkg::REG_BASE_RIGHT: cfg.base_speed_right <= cfg_data[wfpd_pkg::SPEED_W-1:0];
        wfpd_pkg::REG_NO_ECHO:    cfg.no_echo_distance <= cfg_data[wfpd_pkg::DIST_W-1:0];
        wfpd_pkg::REG_MODE:       cfg.steer_mode       <= cfg_data[wfpd_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // step counter and handshakes
  wfpd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .mode      (cfg.steer_mode),
    .ctrl      (ctrl)
  );

  // arithmetic, loop state and output register
  wfpd_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .ctrl          (ctrl),
    .distance_cm   (s_axis_tdata[wfpd_pkg::DIST_W-1:0]),
    .speed_left    (speed_left),
    .speed_right   (speed_right),
    .control_value (control_value)
  );

  assign m_axis_tdata = {5'b00000, control_value, speed_right, speed_left};

  // an accepted item keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input reopened right after an accept");

  // a result only appears as an item finishes its program
  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result produced with no item in flight");

  // control saturates symmetrically, never the most negative code
  a_ctrl_sym: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (control_value != -11'sd1024))
    else $error("control value beyond saturation limit");

endmodule

// ===== tb/wfpd_tb_pkg.sv =====
// wfpd_tb_pkg.sv: steering scoreboard for the wall-following pd block testbench,
// a bit-exact predictor of speeds and control plus the queue of pending results
// depends on wfpd_pkg
`timescale 1ns / 1ps

package wfpd_tb_pkg;
  import wfpd_pkg::*;

  localparam int N_REGS = 8;
  localparam int FRAC = FRAC_BITS_DEF;
  // 0.7 in q8, rounded to nearest
  localparam longint LEAK_DECAY = ((longint'(7) << FRAC) + 5) / 10;
  localparam longint LEAK_HI = 8388607;
  localparam longint LEAK_LO = -8388608;
  // 1.6 as an exact ratio
  localparam longint SCALE_NUM = 16;
  localparam longint SCALE_DEN = 10;
  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef logic [CFG_DATA_W-1:0] reg_file_t [N_REGS];

  typedef struct {
    int speed_left;
    int speed_right;
    int control;
  } drive_t;

  class steering_scoreboard;
    cfg_t    cfg;
    longint  leaky_sum;
    longint  last_error;
    drive_t  expected_drive[$];
    int      errors;
    int      n_results;

    function new();
      cfg = '{target_distance: 4, gain_p: 97, gain_d: 61, gain_i: 0,
              base_speed_left: 60, base_speed_right: 55, no_echo_distance: 200,
              steer_mode: MODE_PLAIN};
      leaky_sum  = 0;
      last_error = 0;
      errors     = 0;
      n_results  = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_TARGET:     cfg.target_distance  = v[DIST_W-1:0];
        REG_GAIN_P:     cfg.gain_p           = v[GAIN_W-1:0];
        REG_GAIN_D:     cfg.gain_d           = v[GAIN_W-1:0];
        REG_GAIN_I:     cfg.gain_i           = v[GAIN_W-1:0];
        REG_BASE_LEFT:  cfg.base_speed_left  = v[SPEED_W-1:0];
        REG_BASE_RIGHT: cfg.base_speed_right = v[SPEED_W-1:0];
        REG_NO_ECHO:    cfg.no_echo_distance = v[DIST_W-1:0];
        REG_MODE:       cfg.steer_mode       = v[MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // drop the fraction, rounding toward zero
    function longint drop_frac(longint v);
      return (v < 0) ? -((-v) >>> FRAC) : (v >>> FRAC);
    endfunction

    function drive_t steer_from_sample(logic [DIST_W-1:0] sample);
      longint dist_cm, err, ctrl, c, mag, left, right, whole, bl, br;
      drive_t d;
      if (sample == '0) dist_cm = longint'(cfg.no_echo_distance);
      else dist_cm = longint'(sample);
      err = longint'(cfg.target_distance) - dist_cm;
      // >>> on a signed longint floors, which gives ties toward plus infinity here
      leaky_sum = ((LEAK_DECAY * leaky_sum + (longint'(1) << (FRAC - 1))) >>> FRAC)
                  + longint'(cfg.gain_i) * err;
      leaky_sum = clip(leaky_sum, LEAK_LO, LEAK_HI);
      ctrl = longint'(cfg.gain_p) * err + longint'(cfg.gain_d) * (err - last_error)
             + leaky_sum;
      bl = longint'(cfg.base_speed_left);
      br = longint'(cfg.base_speed_right);
      if (cfg.steer_mode == MODE_SCALED) begin
        c = -((-ctrl) >>> FRAC);
        mag = ((c < 0) ? -c : c) * SCALE_NUM;
        left  = (bl * SCALE_DEN + mag) / SCALE_DEN;
        right = (br * SCALE_DEN - mag) / SCALE_DEN;
        whole = (c * SCALE_NUM) / SCALE_DEN;
      end else if (cfg.steer_mode == MODE_MIRROR) begin
        left  = drop_frac((bl <<< FRAC) - ctrl);
        right = drop_frac((br <<< FRAC) + ctrl);
        whole = drop_frac(ctrl);
      end else begin
        left  = drop_frac((bl <<< FRAC) + ctrl);
        right = drop_frac((br <<< FRAC) - ctrl);
        whole = drop_frac(ctrl);
      end
      last_error = err;
      d.speed_left  = int'(clip(left, 0, SPEED_MAX));
      d.speed_right = int'(clip(right, 0, SPEED_MAX));
      d.control     = int'(clip(whole, -1023, 1023));
      return d;
    endfunction

    function void note_sample(logic [DIST_W-1:0] sample);
      expected_drive.push_back(steer_from_sample(sample));
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, int got, int want);
      if (got != want)
        report($sformatf("result %0d %s got %0d expected %0d", n_results, name, got, want));
    endtask

    // tdata: [7:0] speed_left, [15:8] speed_right, [26:16] control_value
    task check_result(logic [31:0] data);
      drive_t want;
      if (expected_drive.size() == 0) begin
        report($sformatf("result %0d arrived with no item pending", n_results));
      end else begin
        want = expected_drive.pop_front();
        compare_field("speed_left", int'(data[7:0]), want.speed_left);
        compare_field("speed_right", int'(data[15:8]), want.speed_right);
        compare_field("control_value", int'($signed(data[26:16])), want.control);
      end
      n_results++;
    endtask
  endclass

endpackage

// ===== tb/testbench.sv =====
// testbench.sv: top of the wall-following pd steering testbench; drives distance
// items and register writes, checks every result against the steering scoreboard
// depends on wfpd_pkg, wfpd_tb_pkg and the wall_follow_pd_steering rtl
`timescale 1ns / 1ps

module testbench;
  import wfpd_pkg::*;
  import wfpd_tb_pkg::*;

  localparam int  N_SEGMENTS    = 9;
  localparam int  ITEMS_PER_SEG = 150;
  localparam int  DRAIN_LIMIT   = 4000;
  // a little more than the longest program (9 steps) plus the output register
  localparam int  SETTLE_CYCLES = 12;
  localparam longint TIMEOUT_NS = 5_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // idle percentages for the item sender and the result receiver
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  steering_scoreboard sb;

  wall_follow_pd_steering dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // result side: values read right after the edge are the ones the dut saw at it,
  // so a handshake is tvalid and our own tready both high here
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // one distance item; a random gap first, tvalid stays high across back-to-back items
  task automatic send_sample(input logic [DIST_W-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(16 - DIST_W){1'b0}}, d};   // [8:0] distance_cm, rest zero
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(d);
  endtask

  // stop sending and let every pending result come out, then a short settle
  task automatic drain_results();
    int waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all registers in index order, one per cycle, only while the block is idle
  task automatic load_regs(input reg_file_t v);
    cfg_reg_t r;
    for (int i = 0; i < N_REGS; i++) begin
      r = cfg_reg_t'(i);
      cfg_we   <= 1'b1;
      cfg_addr <= r;
      cfg_data <= v[i];
      sb.set_reg(r, v[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    reg_file_t settings;
    int        r;
    int        near;
    logic [DIST_W-1:0] d;

    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct   = 29;
    sink_stall_pct = 47;

    // directed: reset defaults, no echo, field extremes, on target
    send_sample(9'd0);
    send_sample(9'd511);
    send_sample(9'd500);
    send_sample(9'd1);
    send_sample(9'd4);
    send_sample(9'd256);
    drain_results();

    // every gain and base speed at its top, target and no-echo at 500, scaled steering with ceil and abs
    settings = '{500, 1023, 1023, 1023, 255, 255, 500, MODE_SCALED};
    load_regs(settings);
    send_sample(9'd0);
    send_sample(9'd511);
    send_sample(9'd1);
    send_sample(9'd250);
    send_sample(9'd499);
    send_sample(9'd505);
    drain_results();

    // mirrored steering around a mid base, swings to both sides of target
    settings = '{30, 300, 200, 40, 128, 128, 1, MODE_MIRROR};
    load_regs(settings);
    send_sample(9'd0);
    send_sample(9'd30);
    send_sample(9'd60);
    send_sample(9'd10);
    send_sample(9'd1);
    send_sample(9'd100);
    drain_results();

    // unused mode acts as plain; zero no-echo distance makes a missing echo read 0
    settings = '{20, 97, 61, 10, 60, 55, 0, MODE_SPARE};
    load_regs(settings);
    send_sample(9'd0);
    send_sample(9'd0);
    send_sample(9'd505);
    drain_results();

    // random part: receiver stalls more first, then sender idles more, then no idling
    for (int seg = 0; seg < N_SEGMENTS; seg++) begin
      if (seg < 3) begin
        src_idle_pct   = 29;
        sink_stall_pct = 47;
      end else if (seg < 6) begin
        src_idle_pct   = 47;
        sink_stall_pct = 29;
      end else begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end

      case (seg)
        1: settings = '{500, 1023, 1023, 1023, 255, 255, 500, MODE_PLAIN};
        2: settings = '{0, 0, 0, 0, 0, 0, 1, MODE_PLAIN};
        4: settings = '{0, 1023, 1023, 1023, 0, 255, 500, MODE_PLAIN};
        default: begin
          settings[REG_TARGET] = CFG_DATA_W'($urandom_range(500));
          // mostly modest gains so speeds land inside 0..255 often
          for (int i = REG_GAIN_P; i <= REG_GAIN_I; i++)
            settings[i] = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(1023))
                                                   : CFG_DATA_W'($urandom_range(160));
          settings[REG_BASE_LEFT]  = CFG_DATA_W'($urandom_range(255));
          settings[REG_BASE_RIGHT] = CFG_DATA_W'($urandom_range(255));
          settings[REG_NO_ECHO]    = CFG_DATA_W'($urandom_range(500, 1));
        end
      endcase
      // walk through plain, scaled, mirrored and the unused mode
      settings[REG_MODE] = CFG_DATA_W'(seg % 4);
      load_regs(settings);

      repeat (ITEMS_PER_SEG) begin
        r = $urandom_range(99);
        if (r < 10) begin
          d = '0;
        end else if (r < 20) begin
          d = DIST_W'($urandom_range(511, 501));
        end else if (r < 70) begin
          // near target, where the loop does real work instead of clamping
          near = int'(settings[REG_TARGET]) + int'($urandom_range(40)) - 20;
          if (near < 0) near = 0;
          if (near > 511) near = 511;
          d = near[DIST_W-1:0];
        end else begin
          d = DIST_W'($urandom_range(500, 1));
        end
        send_sample(d);
      end
      drain_results();
    end

    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard stop if the handshakes ever hang
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
